@@ rtl/htab_pkg.sv @@
// ----------------------------------------------------------------------------
// htab_pkg
// Shared types and codes of the 64-bit key hash table.
// ----------------------------------------------------------------------------
package htab_pkg;

  localparam int DEF_MAX_BUCKETS = 1024;
  // Widest slot index carried between front and back (MAX_BUCKETS <= 65536).
  localparam int IDX_MAXW = 16;
  localparam int CFG_W = 11;

  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_ERASE  = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_NEXT   = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EXISTS   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_DEL   = 2'd1;
  localparam logic [1:0] MARK_LIVE  = 2'd2;

  localparam logic REG_BUCKET_COUNT    = 1'b0;
  localparam logic REG_OCCUPANCY_LIMIT = 1'b1;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [63:0] key;
    logic [10:0]        slot;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  found_slot;
    logic [10:0] live_count;
  } rsp_t;

  typedef struct packed {
    logic [2:0]          command;
    logic signed [63:0]  key;
    logic [10:0]         slot;
    logic [IDX_MAXW-1:0] home;
    logic [IDX_MAXW-1:0] step;
  } job_t;

  function automatic logic [31:0] hash_key(input logic signed [63:0] k);
    logic [31:0] sra;
    sra = {k[63], k[63:33]};
    return sra ^ k[31:0] ^ {k[20:0], 11'b0};
  endfunction

endpackage

@@ rtl/htab_front.sv @@
// ----------------------------------------------------------------------------
// htab_front
// Accepts requests, hashes keys and, for lookup and insert, derives home slot and probe step.
// ----------------------------------------------------------------------------
module htab_front #(
  parameter int MAX_BUCKETS = htab_pkg::DEF_MAX_BUCKETS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hold,
  input  logic [$clog2(MAX_BUCKETS+1)-1:0] nb,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  htab_pkg::req_t       req,
  output logic                 job_valid,
  input  logic                 job_ready,
  output htab_pkg::job_t       job
);

  localparam int NBW = $clog2(MAX_BUCKETS + 1);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_LOAD, F_PUSH} fstate_t;

  fstate_t        state;
  htab_pkg::job_t ent;
  logic [31:0]    h;
  logic [NBW-1:0] r1, r2;
  logic [4:0]     cnt;
  logic [NBW:0]   s1, s2;
  logic [NBW-1:0] d2;

  assign d2 = nb - NBW'(1);
  assign s1 = {r1, h[31]};
  assign s2 = {r2, h[31]};

  assign req_ready = (state == F_IDLE) && !hold;
  assign job_valid = (state == F_PUSH);
  assign job       = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req_valid && req_ready) begin
            ent.command <= req.command;
            ent.key     <= req.key;
            ent.slot    <= req.slot;
            ent.home    <= '0;
            ent.step    <= '0;
            h           <= htab_pkg::hash_key(req.key);
            r1          <= '0;
            r2          <= '0;
            cnt         <= '0;
            if (req.command == htab_pkg::CMD_LOOKUP ||
                req.command == htab_pkg::CMD_INSERT) begin
              state <= F_DIV;
            end else begin
              state <= F_PUSH;
            end
          end
        end
        F_DIV: begin
          // one remainder bit per cycle for both divisors
          r1  <= (s1 >= {1'b0, nb}) ? NBW'(s1 - {1'b0, nb}) : NBW'(s1);
          r2  <= (s2 >= {1'b0, d2}) ? NBW'(s2 - {1'b0, d2}) : NBW'(s2);
          h   <= {h[30:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= F_LOAD;
          end
        end
        F_LOAD: begin
          // remainders are final; form home slot and probe step
          ent.home <= htab_pkg::IDX_MAXW'(r1);
          ent.step <= htab_pkg::IDX_MAXW'(r2) + htab_pkg::IDX_MAXW'(1);
          state    <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/htab_queue.sv @@
// ----------------------------------------------------------------------------
// htab_queue
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module htab_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  htab_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output htab_pkg::job_t out_job
);

  htab_pkg::job_t entries [2];
  logic           wptr, rptr;
  logic [1:0]     count;
  logic           push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = entries[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/htab_back.sv @@
// ----------------------------------------------------------------------------
// htab_back
// Probes the slot store and carries out each job; holds the response.
// ----------------------------------------------------------------------------
module htab_back #(
  parameter int MAX_BUCKETS = htab_pkg::DEF_MAX_BUCKETS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [$clog2(MAX_BUCKETS+1)-1:0] nb,
  input  logic [htab_pkg::CFG_W-1:0]       limit,
  output logic                 init_busy,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  htab_pkg::job_t       job,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output htab_pkg::rsp_t       rsp
);

  localparam int IW  = $clog2(MAX_BUCKETS);
  localparam int NBW = $clog2(MAX_BUCKETS + 1);
  localparam int XW  = (NBW > htab_pkg::CFG_W) ? NBW : htab_pkg::CFG_W;

  typedef struct packed {
    logic [1:0]         mark;
    logic signed [63:0] key;
  } entry_t;

  typedef enum logic [2:0] {B_INIT, B_IDLE, B_RD, B_CHK, B_CLR, B_EMIT} bstate_t;

  entry_t             mem [MAX_BUCKETS];
  entry_t             rdata;
  entry_t             wdata;
  logic               we;
  logic [IW-1:0]      waddr;

  bstate_t            state;
  logic [2:0]         cmd;
  logic signed [63:0] key;
  logic [IW-1:0]      home, step, cur, site, ptr;
  logic               site_vld;
  logic [NBW-1:0]     live, used;
  logic [1:0]         res_status;
  logic [IW-1:0]      res_slot;

  logic [NBW:0]       sum;
  logic [IW-1:0]      nxt;
  logic [IW-1:0]      site_eff;
  logic               site_vld_eff;
  logic               cont;
  logic               slot_in;

  assign init_busy = (state == B_INIT);
  assign job_ready = (state == B_IDLE);

  assign sum = {1'b0, NBW'(cur)} + {1'b0, NBW'(step)};
  assign nxt = (sum >= {1'b0, nb}) ? IW'(sum - {1'b0, nb}) : IW'(sum);
  assign cont = (rdata.mark != htab_pkg::MARK_EMPTY) &&
                ((rdata.mark == htab_pkg::MARK_DEL) || (rdata.key != key));
  assign site_eff     = (rdata.mark == htab_pkg::MARK_DEL) ? cur : site;
  assign site_vld_eff = (rdata.mark == htab_pkg::MARK_DEL) || site_vld;
  assign slot_in      = XW'(job.slot) < XW'(nb);

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = '{mark: htab_pkg::MARK_LIVE, key: key};
    case (state)
      B_INIT, B_CLR: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = '{mark: htab_pkg::MARK_EMPTY, key: '0};
      end
      B_CHK: begin
        case (cmd)
          htab_pkg::CMD_INSERT: begin
            if (cont) begin
              if (nxt == home && site_vld_eff) begin
                we    = 1'b1;
                waddr = site_eff;
              end
            end else if (rdata.mark != htab_pkg::MARK_LIVE) begin
              we    = 1'b1;
              waddr = site_vld ? site : cur;
            end
          end
          htab_pkg::CMD_ERASE: begin
            if (rdata.mark == htab_pkg::MARK_LIVE) begin
              we    = 1'b1;
              wdata = '{mark: htab_pkg::MARK_DEL, key: rdata.key};
            end
          end
          default: we = 1'b0;
        endcase
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      ptr       <= '0;
      live      <= '0;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the response once taken, unless a new one loads this cycle
      if (rsp_valid && rsp_ready && state != B_EMIT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        B_INIT: begin
          ptr <= ptr + IW'(1);
          if (ptr == IW'(MAX_BUCKETS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_valid) begin
            cmd        <= job.command;
            key        <= job.key;
            home       <= IW'(job.home);
            step       <= IW'(job.step);
            site_vld   <= 1'b0;
            res_status <= htab_pkg::ST_NOTFOUND;
            res_slot   <= '0;
            case (job.command)
              htab_pkg::CMD_LOOKUP, htab_pkg::CMD_INSERT: begin
                cur <= IW'(job.home);
                if (job.command == htab_pkg::CMD_INSERT &&
                    XW'(used) >= XW'(limit)) begin
                  res_status <= htab_pkg::ST_FULL;
                  state      <= B_EMIT;
                end else begin
                  state <= B_RD;
                end
              end
              htab_pkg::CMD_ERASE, htab_pkg::CMD_NEXT: begin
                cur <= IW'(job.slot);
                state <= slot_in ? B_RD : B_EMIT;
              end
              htab_pkg::CMD_CLEAR: begin
                ptr   <= '0;
                state <= B_CLR;
              end
              default: state <= B_EMIT;
            endcase
          end
        end
        B_RD: state <= B_CHK;
        B_CHK: begin
          state <= B_EMIT;
          case (cmd)
            htab_pkg::CMD_LOOKUP, htab_pkg::CMD_INSERT: begin
              if (cont) begin
                site     <= site_eff;
                site_vld <= site_vld_eff;
                if (nxt == home) begin
                  if (cmd == htab_pkg::CMD_INSERT) begin
                    if (site_vld_eff) begin
                      live       <= live + NBW'(1);
                      res_status <= htab_pkg::ST_DONE;
                      res_slot   <= site_eff;
                    end else begin
                      res_status <= htab_pkg::ST_FULL;
                    end
                  end
                end else begin
                  cur   <= nxt;
                  state <= B_RD;
                end
              end else if (rdata.mark == htab_pkg::MARK_LIVE) begin
                res_status <= (cmd == htab_pkg::CMD_LOOKUP) ?
                              htab_pkg::ST_DONE : htab_pkg::ST_EXISTS;
                res_slot   <= cur;
              end else if (cmd == htab_pkg::CMD_INSERT) begin
                live       <= live + NBW'(1);
                res_status <= htab_pkg::ST_DONE;
                if (site_vld) begin
                  res_slot <= site;
                end else begin
                  res_slot <= cur;
                  used     <= used + NBW'(1);
                end
              end
            end
            htab_pkg::CMD_ERASE: begin
              if (rdata.mark == htab_pkg::MARK_LIVE) begin
                live       <= live - NBW'(1);
                res_status <= htab_pkg::ST_DONE;
                res_slot   <= cur;
              end
            end
            htab_pkg::CMD_NEXT: begin
              if (rdata.mark == htab_pkg::MARK_LIVE) begin
                res_status <= htab_pkg::ST_DONE;
                res_slot   <= cur;
              end else if (NBW'(cur) + NBW'(1) != nb) begin
                cur   <= cur + IW'(1);
                state <= B_RD;
              end
            end
            default: state <= B_EMIT;
          endcase
        end
        B_CLR: begin
          ptr <= ptr + IW'(1);
          if (ptr == IW'(MAX_BUCKETS - 1)) begin
            live       <= '0;
            used       <= '0;
            res_status <= htab_pkg::ST_DONE;
            state      <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.found_slot  <= 10'(res_slot);
            rsp.live_count  <= 11'(live);
            state           <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/hash_table_int64_keys.sv @@
// ----------------------------------------------------------------------------
// hash_table_int64_keys
// Open-addressing hash set of signed 64-bit keys with double hashing.
// ----------------------------------------------------------------------------
// Each request is one command: lookup, insert, erase by slot, clear, or scan
// for the next live slot; each yields exactly one response with status, slot
// and live key count. For lookup and insert the front runs two bit-serial
// remainder units in parallel that form the home slot (hash mod buckets) and
// the probe step (1 + hash mod (buckets - 1)) one bit per cycle; then, for
// each probed slot, the back does a registered store read, then a compare,
// and finally loads the response. Next reads and compares each slot scanned;
// clear writes one store row per cycle. A two-entry job queue lets the front
// hash the following request while the back probes. After reset the back
// sweeps every store row to empty with req_ready low; config writes are
// taken throughout.
// ----------------------------------------------------------------------------
module hash_table_int64_keys #(
  parameter int MAX_BUCKETS = htab_pkg::DEF_MAX_BUCKETS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  htab_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output htab_pkg::rsp_t             rsp,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [htab_pkg::CFG_W-1:0] cfg_data
);

  localparam int NBW = $clog2(MAX_BUCKETS + 1);
  localparam int XW  = (NBW > htab_pkg::CFG_W) ? NBW : htab_pkg::CFG_W;

  logic [htab_pkg::CFG_W-1:0] bucket_count;
  logic [htab_pkg::CFG_W-1:0] occupancy_limit;
  logic [NBW-1:0]             nb;
  logic                       init_busy;
  logic                       fq_valid, fq_ready, qb_valid, qb_ready;
  htab_pkg::job_t             fq_job, qb_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count    <= htab_pkg::CFG_W'(769);
      occupancy_limit <= htab_pkg::CFG_W'(592);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        htab_pkg::REG_BUCKET_COUNT:    bucket_count    <= cfg_data;
        htab_pkg::REG_OCCUPANCY_LIMIT: occupancy_limit <= cfg_data;
        default:                       bucket_count    <= bucket_count;
      endcase
    end
  end

  // saturate the bucket count into [3, MAX_BUCKETS]
  always_comb begin
    if (XW'(bucket_count) < XW'(3)) begin
      nb = NBW'(3);
    end else if (XW'(bucket_count) > XW'(MAX_BUCKETS)) begin
      nb = NBW'(MAX_BUCKETS);
    end else begin
      nb = NBW'(bucket_count);
    end
  end

  htab_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (init_busy),
    .nb        (nb),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  htab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  htab_back #(.MAX_BUCKETS(MAX_BUCKETS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .nb        (nb),
    .limit     (occupancy_limit),
    .init_busy (init_busy),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
